// ===== sv/i2c_master_write_then_read_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_THEN_READ_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_WRITE_THEN_READ_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define I2CWR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cwr: same-cycle check failed");

// next-cycle implication
`define I2CWR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cwr: next-cycle check failed");

`endif

// ===== sv/i2cwr_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer package
// Beat types, widths and status and acknowledge codes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cwr_pkg;

   localparam int LEN_BITS     = 8;
   localparam int TIMEOUT_BITS = 8;

   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(100);

   localparam logic [2:0] STATUS_BUSY      = 3'd0;
   localparam logic [2:0] STATUS_DONE      = 3'd1;
   localparam logic [2:0] STATUS_ADDR_NACK = 3'd2;
   localparam logic [2:0] STATUS_DATA_NACK = 3'd3;
   localparam logic [2:0] STATUS_TIMEOUT   = 3'd4;

   localparam logic [1:0] ACK_KEEP    = 2'd0;
   localparam logic [1:0] ACK_ENABLE  = 2'd1;
   localparam logic [1:0] ACK_DISABLE = 2'd2;

   typedef struct packed {
      logic       sb_flag;
      logic       addr_flag;
      logic       btf_flag;
      logic       af_flag;
      logic       rxne_flag;
      logic [7:0] rx_data;
      logic [7:0] tx_data;
      logic [6:0] slave_address;
      logic [7:0] write_length;
      logic [7:0] read_length;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic       gen_start;
      logic       gen_stop;
      logic [1:0] ack_control;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       addr_clear;
      logic       rx_valid;
      logic [7:0] rx_index;
      logic [7:0] rx_out;
      logic [7:0] next_write_index;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== sv/i2c_master_write_then_read_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master write-then-read sequencer
// Each request beat is one poll of an I2C byte engine's flags; each poll gives
// exactly one response beat with the start, stop, acknowledge, transmit and
// receive commands for the engine and a status (busy, done, address nack,
// data nack, timeout). A transfer runs start, write address, write bytes,
// repeated start, read address, address clear and read bytes, then returns
// to start. One poll is taken every clock unless the response stalls; a
// poll waits in the input register and its response is registered in the
// result register. A stalled response holds the input register, which then
// stalls the request side. The user must write the timeout limit (reset 100)
// through the csr port while no poll is in flight; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_write_then_read_sequencer_assert.svh"

module i2c_master_write_then_read_sequencer import i2cwr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_data,
   input  logic                    csr_wr_en,
   input  logic [TIMEOUT_BITS-1:0] csr_wr_data
);

   logic         in_valid;
   req_item_type in_item;
   logic         in_take;

   i2cwr_inreg u_inreg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .in_take   (in_take)
   );

   i2cwr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (in_valid),
      .in_item     (in_item),
      .in_take     (in_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `I2CWR_ASSERT_SAME(a_end_has_stop, rsp_valid && rsp_data.status != STATUS_BUSY, rsp_data.gen_stop)
   `I2CWR_ASSERT_SAME(a_stall_chain, in_valid && rsp_valid && rsp_stall, req_stall)
   `I2CWR_ASSERT_NEXT(a_poll_answers, in_valid && !rsp_valid, rsp_valid)

endmodule

`default_nettype wire

// ===== sv/i2cwr_inreg.sv =====
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer input stage
// Registers one request beat and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cwr_inreg import i2cwr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         in_valid,
   output req_item_type in_item,
   input  logic         in_take
);

   logic         valid_ff;
   req_item_type item_ff;

   assign req_stall = valid_ff && !in_take;
   assign in_valid  = valid_ff;
   assign in_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/i2cwr_seq.sv =====
// ----------------------------------------------------------------------------
// I2C write-then-read sequencer core
// Phase machine, byte and timeout counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cwr_seq import i2cwr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [TIMEOUT_BITS-1:0] csr_wr_data,
   input  logic                    in_valid,
   input  req_item_type            in_item,
   output logic                    in_take,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_data
);

   typedef enum logic [2:0] {
      PH_START      = 3'd0,
      PH_WR_ADDR    = 3'd1,
      PH_WR_BYTES   = 3'd2,
      PH_RESTART    = 3'd3,
      PH_RD_ADDR    = 3'd4,
      PH_CLEAR_ADDR = 3'd5,
      PH_RD_BYTES   = 3'd6
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [LEN_BITS-1:0]     count_ff, count_in;
   logic [LEN_BITS-1:0]     wlen_ff, wlen_in;
   logic [LEN_BITS-1:0]     rlen_ff, rlen_in;
   logic [TIMEOUT_BITS-1:0] stall_ff, stall_in, stall_sat;
   logic [TIMEOUT_BITS-1:0] timeout_ff;
   logic                    rsp_valid_ff;
   rsp_item_type            rsp_data_ff, rsp_data_in;
   logic                    ended;
   logic                    fire;

   assign in_take   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid && in_take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stall_sat = (stall_ff == '1) ? stall_ff : stall_ff + TIMEOUT_BITS'(1);

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      wlen_in     = wlen_ff;
      rlen_in     = rlen_ff;
      stall_in    = stall_ff;
      rsp_data_in = '0;
      ended       = 1'b0;

      case (phase_ff)
         PH_WR_ADDR: begin
            if (in_item.sb_flag) begin
               rsp_data_in.tx_valid = 1'b1;
               rsp_data_in.tx_byte  = {in_item.slave_address, 1'b0};
               phase_in             = PH_WR_BYTES;
            end else begin
               stall_in = stall_sat;
            end
         end
         PH_WR_BYTES: begin
            if (in_item.addr_flag) begin
               if (in_item.af_flag) begin
                  rsp_data_in.gen_stop = 1'b1;
                  rsp_data_in.status   = STATUS_ADDR_NACK;
                  phase_in             = PH_START;
                  ended                = 1'b1;
               end else begin
                  rsp_data_in.addr_clear = 1'b1;
                  rsp_data_in.tx_valid   = 1'b1;
                  rsp_data_in.tx_byte    = in_item.tx_data;
                  count_in               = LEN_BITS'(1);
                  phase_in               = PH_RESTART;
                  stall_in               = '0;
               end
            end else begin
               stall_in = stall_sat;
            end
         end
         PH_RESTART: begin
            if (in_item.btf_flag) begin
               if (in_item.af_flag) begin
                  rsp_data_in.gen_stop = 1'b1;
                  rsp_data_in.status   = STATUS_DATA_NACK;
                  phase_in             = PH_START;
                  ended                = 1'b1;
               end else begin
                  stall_in = '0;
                  if (count_ff < wlen_ff) begin
                     rsp_data_in.tx_valid = 1'b1;
                     rsp_data_in.tx_byte  = in_item.tx_data;
                     count_in             = count_ff + LEN_BITS'(1);
                  end else begin
                     rsp_data_in.gen_start = 1'b1;
                     phase_in              = PH_RD_ADDR;
                  end
               end
            end else begin
               stall_in = stall_sat;
            end
         end
         PH_RD_ADDR: begin
            if (in_item.sb_flag) begin
               rsp_data_in.tx_valid = 1'b1;
               rsp_data_in.tx_byte  = {in_item.slave_address, 1'b1};
               phase_in             = PH_CLEAR_ADDR;
               if (rlen_ff == LEN_BITS'(1)) begin
                  rsp_data_in.ack_control = ACK_DISABLE;
               end
            end else begin
               stall_in = stall_sat;
            end
         end
         PH_CLEAR_ADDR: begin
            if (in_item.addr_flag) begin
               if (in_item.af_flag) begin
                  rsp_data_in.gen_stop = 1'b1;
                  rsp_data_in.status   = STATUS_ADDR_NACK;
                  phase_in             = PH_START;
                  ended                = 1'b1;
               end else begin
                  rsp_data_in.addr_clear = 1'b1;
                  count_in               = '0;
                  phase_in               = PH_RD_BYTES;
                  stall_in               = '0;
               end
            end else begin
               stall_in = stall_sat;
            end
         end
         PH_RD_BYTES: begin
            if (rlen_ff > LEN_BITS'(1) && count_ff == rlen_ff - LEN_BITS'(2)) begin
               rsp_data_in.ack_control = ACK_DISABLE;
            end
            if (in_item.rxne_flag) begin
               rsp_data_in.rx_valid = 1'b1;
               rsp_data_in.rx_index = 8'(count_ff);
               rsp_data_in.rx_out   = in_item.rx_data;
               count_in             = count_ff + LEN_BITS'(1);
               if (count_in >= rlen_ff) begin
                  rsp_data_in.gen_stop    = 1'b1;
                  rsp_data_in.ack_control = ACK_ENABLE;
                  rsp_data_in.status      = STATUS_DONE;
                  phase_in                = PH_START;
                  ended                   = 1'b1;
               end
            end else begin
               stall_in = stall_sat;
            end
         end
         default: begin
            stall_in                = '0;
            count_in                = '0;
            wlen_in                 = LEN_BITS'(in_item.write_length);
            rlen_in                 = LEN_BITS'(in_item.read_length);
            rsp_data_in.gen_start   = 1'b1;
            rsp_data_in.ack_control = ACK_ENABLE;
            phase_in                = PH_WR_ADDR;
         end
      endcase

      if (!ended && stall_in > timeout_ff) begin
         rsp_data_in.gen_stop = 1'b1;
         rsp_data_in.status   = STATUS_TIMEOUT;
         phase_in             = PH_START;
      end

      if (phase_in inside {PH_WR_ADDR, PH_WR_BYTES, PH_RESTART}) begin
         rsp_data_in.next_write_index = 8'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         count_ff     <= '0;
         wlen_ff      <= '0;
         rlen_ff      <= '0;
         stall_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (fire) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            wlen_ff      <= wlen_in;
            rlen_ff      <= rlen_in;
            stall_ff     <= stall_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
